// ===== rtl/decimal_radix_sorter_macros.svh =====
// assertion helpers for the sorter top level
`ifndef DECIMAL_RADIX_SORTER_MACROS_SVH
`define DECIMAL_RADIX_SORTER_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define DRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DRS_ASSERT(lbl, prop, msg)
`define DRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/drs_pkg.sv =====
`timescale 1ns / 1ps

package drs_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 31;
    localparam int KEY_W    = 31;
    localparam int DATA_W   = ((KEY_W + 7) / 8) * 8;

    typedef logic [KEY_BITS-1:0] t_key;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

// ===== rtl/drs_cell.sv =====
`timescale 1ns / 1ps

module drs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  drs_pkg::t_cell_ctrl i_ctrl,
    input  drs_pkg::t_key     i_in_key,
    input  drs_pkg::t_key     i_prev_key,
    input  logic              i_prev_valid,
    input  logic              i_prev_take,
    input  drs_pkg::t_key     i_next_key,
    input  logic              i_next_valid,
    output drs_pkg::t_key     o_key,
    output logic              o_valid,
    output logic              o_take
);
    import drs_pkg::*;

    t_key r_key;
    logic r_valid;
    t_key n_key;
    logic n_valid;

    // empty cells count as larger than any key
    assign o_take  = !r_valid || (i_in_key < r_key);
    assign o_key   = r_key;
    assign o_valid = r_valid;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_key   = i_next_key;
            n_valid = i_next_valid;
        end else if (i_ctrl.insert && o_take) begin
            // displaced neighbor moves up, or the new word lands here
            n_key   = i_prev_take ? i_prev_key : i_in_key;
            n_valid = r_valid | i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ===== rtl/decimal_radix_sorter.sv =====
// load: one word per cycle, tready high whenever no sorted run is pending
// the chain keeps words in order as they arrive, so no extra sort time
// first result in the cycle after the word marked last; then one per cycle while m_axis_tready is high
// a set of n words occupies the block while it loads and until its min(n, 64) sorted words drain
// synchronous active-low reset empties the chain and clears the overflow flag
`timescale 1ns / 1ps
`include "decimal_radix_sorter_macros.svh"

module decimal_radix_sorter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [drs_pkg::DATA_W-1:0] s_axis_tdata,   // key
    input  logic                      s_axis_tlast,   // last_key
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [drs_pkg::DATA_W-1:0] m_axis_tdata,   // sorted_key
    output logic                      m_axis_tlast,   // last_result
    output logic                      m_axis_tuser    // overflow
);
    import drs_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic       r_dropped;
    logic       n_dropped;
    t_cell_ctrl w_ctrl;
    t_key       w_in_key;
    t_key       w_key [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_take;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;

    assign w_in_key  = s_axis_tdata[KEY_BITS-1:0];
    assign w_full    = w_valid[DEPTH-1];
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_key w_prev_key;
            logic w_prev_valid;
            logic w_prev_take;
            t_key w_next_key;
            logic w_next_valid;

            if (g == 0) begin : g_head
                assign w_prev_key   = w_in_key;
                assign w_prev_valid = 1'b1;
                assign w_prev_take  = 1'b0;
            end else begin : g_body
                assign w_prev_key   = w_key[g-1];
                assign w_prev_valid = w_valid[g-1];
                assign w_prev_take  = w_take[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_key   = w_key[g];
                assign w_next_valid = 1'b0;
            end else begin : g_mid
                assign w_next_key   = w_key[g+1];
                assign w_next_valid = w_valid[g+1];
            end

            drs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_in_key     (w_in_key),
                .i_prev_key   (w_prev_key),
                .i_prev_valid (w_prev_valid),
                .i_prev_take  (w_prev_take),
                .i_next_key   (w_next_key),
                .i_next_valid (w_next_valid),
                .o_key        (w_key[g]),
                .o_valid      (w_valid[g]),
                .o_take       (w_take[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && s_axis_tlast) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_out_acc && m_axis_tlast) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_LOAD:  s_axis_tready = 1'b1;
            ST_DRAIN: m_axis_tvalid = w_valid[0];
            default: begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    assign m_axis_tdata = DATA_W'(w_key[0]);
    assign m_axis_tlast = w_valid[0] && !w_valid[1];
    assign m_axis_tuser = r_dropped;

    always_comb begin
        n_dropped = r_dropped;
        if (w_out_acc && m_axis_tlast) begin
            n_dropped = 1'b0;
        end else if (w_in_acc && w_full) begin
            n_dropped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

    // occupied cells always form an unbroken run from the head
    `DRS_ASSERT(a_valid_prefix, ((w_valid[DEPTH-1:1] & ~w_valid[DEPTH-2:0]) == '0), "gap in cell chain")
    `DRS_ASSERT(a_drain_nonempty, (r_state == ST_DRAIN |-> w_valid[0]), "drain with empty chain")
    `DRS_ASSERT_ALWAYS(a_one_side, (!(s_axis_tready && m_axis_tvalid)), "load and drain overlap")
    `DRS_ASSERT(a_drop_full, ((r_dropped && r_state == ST_LOAD) |-> w_full), "overflow without full chain")
    `DRS_ASSERT(a_last_empties, (w_out_acc && m_axis_tlast |=> (w_valid == '0) && (r_state == ST_LOAD)), "chain not empty after last word")

endmodule

// ===== tb/decimal_radix_sorter_tb.sv =====
`timescale 1ns / 1ps

module decimal_radix_sorter_tb;
    import drs_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
    localparam int RANDOM_WORDS   = 30;

    typedef struct packed {
        t_key key;
        logic last;
        logic ovf;
    } t_sorted_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;   // [30:0] key, [31] zero
    logic              s_axis_tlast = 1'b0; // last_key
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;        // [30:0] sorted_key, [31] zero
    logic              m_axis_tlast;        // last_result
    logic              m_axis_tuser;        // overflow

    // predictor state: keys of the set being loaded and the sorted words still owed
    t_key         load_keys[$];
    bit           load_dropped;
    t_sorted_word sorted_q[$];

    int n_words;
    int n_sets;
    int n_ovf_sets;
    int n_checked;
    int n_errors;
    int idle_cycles;
    int stall_left;
    int hold_req;
    int hold_ack;
    bit rx_stalls_on;
    bit tx_gaps_on;
    bit tx_offering;

    decimal_radix_sorter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // store a word, or flag a drop once DEPTH are held; on the closing word emit the set in ascending order
    function automatic void load_word(t_key key, logic last);
        t_key         run[$];
        t_key         tmp;
        t_sorted_word w;
        int           j;
        if (load_keys.size() < DEPTH)
            load_keys.push_back(key);
        else
            load_dropped = 1'b1;
        if (last) begin
            run = load_keys;
            for (int i = 1; i < run.size(); i++) begin
                tmp = run[i];
                j = i - 1;
                while (j >= 0 && run[j] > tmp) begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = tmp;
            end
            foreach (run[i]) begin
                w.key  = run[i];
                w.last = (i == run.size() - 1);
                w.ovf  = load_dropped;
                sorted_q.push_back(w);
            end
            n_sets++;
            if (load_dropped)
                n_ovf_sets++;
            load_keys.delete();
            load_dropped = 1'b0;
        end
    endfunction

    function automatic t_key rand_key();
        int pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0: return t_key'($urandom_range(0, 9));
            1: return t_key'($urandom_range(0, 99999));
            2: begin
                // repeat a key already in the set to exercise ties
                if (load_keys.size() != 0)
                    return load_keys[$urandom_range(0, load_keys.size() - 1)];
                return t_key'($urandom);
            end
            default: return t_key'($urandom);
        endcase
    endfunction

    task automatic send_word(input t_key key, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DATA_W - KEY_BITS){1'b0}}, key};
        s_axis_tlast  <= last;
        tx_offering = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        load_word(key, last);
        n_words++;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            tx_offering = 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_keys(input t_key keys[$]);
        foreach (keys[i])
            send_word(keys[i], i == keys.size() - 1);
    endtask

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_word(rand_key(), i == len - 1);
    endtask

    // sender goes quiet until the block has handed back every word owed
    task automatic wait_drained();
        if (tx_offering)
            s_axis_tvalid <= 1'b0;
        tx_offering = 1'b0;
        while (sorted_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_keys('{31'd0});
        send_keys('{31'h7FFF_FFFF});
        send_keys('{31'd9, 31'd10, 31'd1, 31'd0, 31'd99, 31'd100, 31'h7FFF_FFFF,
                    31'd1_000_000_000});
        send_keys('{31'd5, 31'd5, 31'd3, 31'd5});
        send_keys('{31'h2AAA_AAAA, 31'h5555_5555, 31'd999_999_999, 31'd1_000_000_000,
                    31'd7});
        wait_drained();
    endtask

    task automatic test_full_store();
        // exactly full, then three words too many with the closing one dropped
        send_random_set(DEPTH);
        send_random_set(DEPTH + 3);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        send_random_set(12);
        send_random_set(12);
        send_random_set(5);
        wait_drained();
    endtask

    task automatic test_random();
        int start;
        int len;
        start = n_words;
        while (n_words - start < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(DEPTH - 2, DEPTH + 4);
            else
                len = $urandom_range(1, 12);
            send_random_set(len);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_gaps_on = 1'b0;
        rx_stalls_on <= 1'b0;
        repeat (4) send_random_set($urandom_range(1, 10));
        wait_drained();
    endtask

    // sink side: random stall bursts, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_ack <= 0;
        end else if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            stall_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected word key=%0d last=%0b ovf=%0b", $time,
                         m_axis_tdata[KEY_BITS-1:0], m_axis_tlast, m_axis_tuser);
                n_errors++;
            end else begin
                want = sorted_q.pop_front();
                n_checked++;
                if (m_axis_tdata[KEY_BITS-1:0] !== want.key) begin
                    $display("%0t: sorted_key expected %0d actual %0d", $time, want.key,
                             m_axis_tdata[KEY_BITS-1:0]);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last_result expected %0b actual %0b", $time, want.last,
                             m_axis_tlast);
                    n_errors++;
                end
                if (m_axis_tuser !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b", $time, want.ovf,
                             m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("FAIL decimal_radix_sorter");
                $finish;
            end
        end
    end

    initial begin
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        load_dropped = 1'b0;
        tx_offering = 1'b0;
        hold_req = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random();
        test_back_to_back();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d words in %0d sets (%0d with dropped words), checked %0d sorted words",
                 n_words, n_sets, n_ovf_sets, n_checked);
        $display("covered extreme and tied keys, full and overrun stores, long sink hold-off");
        if (n_errors == 0 && sorted_q.size() == 0) begin
            $display("PASS decimal_radix_sorter");
        end else begin
            $display("%0d errors, %0d words never arrived", n_errors, sorted_q.size());
            $display("FAIL decimal_radix_sorter");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_cell.sv
rtl/decimal_radix_sorter.sv
tb/decimal_radix_sorter_tb.sv
